// ===== rtl/matrix3x3_inverse_core_defines.svh =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core_defines
// Assertion macros shared by the 3x3 inverse core.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3X3_INVERSE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define MI3_CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define MI3_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and types of the 3x3 inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int N_ELEM = 9;

  // 2x2 minor per adjugate entry: adj = m[A]*m[D] - m[B]*m[C]
  localparam int MA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int MD [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int MB [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int MC [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // adjugate entries that pair with row 0 in the determinant
  localparam int DET_COL [3] = '{0, 3, 6};

  typedef struct packed {
    logic vld;
    logic sing;
  } tag_t;

endpackage

// ===== rtl/mi3_if.sv =====
// ----------------------------------------------------------------------------
// mi3_if
// Valid/ready channels for matrix beats and inverse beats.
// ----------------------------------------------------------------------------
interface mi3_mat_if #(parameter int IN_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [IN_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

interface mi3_res_if #(parameter int OUT_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [OUT_WIDTH-1:0] inv00, inv01, inv02, inv10, inv11, inv12;
  logic signed [OUT_WIDTH-1:0] inv20, inv21, inv22;
  logic ok;

  modport source (
    output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, ok,
    input  ready
  );
  modport sink (
    input  valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, ok,
    output ready
  );
endinterface

// ===== rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// Four-stage adjugate and determinant pipeline.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int IN_WIDTH = 24,
  localparam int AW = 2*IN_WIDTH + 1,
  localparam int DW = 3*IN_WIDTH + 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic signed [IN_WIDTH-1:0] m [mi3_pkg::N_ELEM],
  output logic                       out_vld,
  output logic signed [AW-1:0]       adj [mi3_pkg::N_ELEM],
  output logic signed [DW-1:0]       det
);

  localparam int PW  = 2*IN_WIDTH;
  localparam int LO  = IN_WIDTH + 1;
  localparam int PHW = IN_WIDTH + (AW - LO);
  localparam int PLW = IN_WIDTH + LO + 1;

  logic [3:0]                vld;
  logic signed [PW-1:0]      pad [mi3_pkg::N_ELEM];
  logic signed [PW-1:0]      pbc [mi3_pkg::N_ELEM];
  logic signed [AW-1:0]      adj2 [mi3_pkg::N_ELEM];
  logic signed [AW-1:0]      adj3 [mi3_pkg::N_ELEM];
  logic signed [IN_WIDTH-1:0] row1 [3];
  logic signed [IN_WIDTH-1:0] row2 [3];
  logic signed [PHW-1:0]     ph [3];
  logic signed [PLW-1:0]     pl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
        pad[i]  <= m[mi3_pkg::MA[i]] * m[mi3_pkg::MD[i]];
        pbc[i]  <= m[mi3_pkg::MB[i]] * m[mi3_pkg::MC[i]];
        adj2[i] <= AW'(pad[i]) - AW'(pbc[i]);
        adj3[i] <= adj2[i];
        adj[i]  <= adj3[i];
      end
      for (int j = 0; j < 3; j++) begin
        row1[j] <= m[j];
        row2[j] <= row1[j];
        ph[j]   <= row2[j] * $signed(adj2[mi3_pkg::DET_COL[j]][AW-1:LO]);
        pl[j]   <= row2[j] * $signed({1'b0, adj2[mi3_pkg::DET_COL[j]][LO-1:0]});
      end
      det <= (DW'(ph[0]) <<< LO) + (DW'(ph[1]) <<< LO) + (DW'(ph[2]) <<< LO)
           + DW'(pl[0]) + DW'(pl[1]) + DW'(pl[2]);
    end
  end

  assign out_vld = vld[3];

endmodule

// ===== rtl/mi3_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_lane
// One output element: restoring divide, one quotient bit per stage, round.
// ----------------------------------------------------------------------------
module mi3_lane #(
  parameter int IN_WIDTH  = 24,
  parameter int OUT_WIDTH = 32,
  parameter int FRAC_BITS = 20,
  localparam int AW = 2*IN_WIDTH + 1,
  localparam int DW = 3*IN_WIDTH + 3
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] adj,
  input  logic signed [DW-1:0] det,
  output logic [OUT_WIDTH-1:0] quo,
  output logic                 fit
);

  localparam int SH = 2*FRAC_BITS + 1;
  localparam int QB = OUT_WIDTH + 1;
  localparam int RW = DW + QB;
  localparam int NW = AW + SH;
  localparam int CW = (NW > RW) ? NW : RW;

  logic [AW-1:0] amag;
  logic [DW-1:0] dmag;
  logic [CW-1:0] num;
  logic [CW-1:0] dlim;

  logic [RW-1:0] rem  [QB+1];
  logic [QB-1:0] quot [QB+1];
  logic [DW-1:0] dv   [QB+1];
  logic          sgn  [QB+1];
  logic          ovf  [QB+1];

  logic [QB:0]   qr;
  logic [QB-1:0] qh;
  logic          big;
  logic          half;

  assign amag = adj[AW-1] ? AW'(-adj) : AW'(adj);
  assign dmag = det[DW-1] ? DW'(-det) : DW'(det);
  assign num  = CW'(amag) << SH;
  assign dlim = CW'(dmag) << QB;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num[RW-1:0];
      quot[0] <= '0;
      dv[0]   <= dmag;
      sgn[0]  <= adj[AW-1] ^ det[DW-1];
      ovf[0]  <= (num >= dlim);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic [RW:0] trial;
    logic        take;

    assign trial = {1'b0, rem[k]} - ((RW+1)'(dv[k]) << B);
    assign take  = ~trial[RW];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? trial[RW-1:0] : rem[k];
        quot[k+1] <= quot[k] | (take ? (QB'(1) << B) : QB'(0));
        dv[k+1]   <= dv[k];
        sgn[k+1]  <= sgn[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  assign qr   = (QB+1)'(quot[QB]) + (QB+1)'(1);
  assign qh   = qr[QB:1];
  assign big  = (qh[QB-1:OUT_WIDTH-1] != '0);
  assign half = (qh == (QB'(1) << (OUT_WIDTH-1)));

  always_ff @(posedge clk) begin
    if (en) begin
      fit <= ~ovf[QB] & (~big | (sgn[QB] & half));
      quo <= sgn[QB] ? (-qh[OUT_WIDTH-1:0]) : qh[OUT_WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/mi3_outq.sv =====
// ----------------------------------------------------------------------------
// mi3_outq
// Two-entry output queue; parts the pipeline from the result channel.
// ----------------------------------------------------------------------------
module mi3_outq #(
  parameter int WIDTH = 289
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_vld,
  input  logic             out_rdy,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] ent [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             pop;

  assign pop      = out_vld & out_rdy;
  assign full     = (cnt == 2'd2);
  assign out_vld  = (cnt != 2'd0);
  assign out_data = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= push_data;
    end
  end

endmodule

// ===== rtl/matrix3x3_inverse_core.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// 3x3 fixed-point matrix inverse by adjugate and exact rounded division.
//
//   channel  dir  beat
//   mat      in   nine Q3.20 elements m00..m22
//   res      out  nine Q11.20 elements inv00..inv22, ok
//
// One beat per cycle. The path runs through four adjugate/determinant
// stages, one stage per quotient bit (OUT_WIDTH + 1) plus setup and
// rounding in each lane, then the output queue. rst clears valid bits
// and the queue. The pipeline holds only when the two-entry output
// queue is full.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_core_defines.svh"

module matrix3x3_inverse_core #(
  parameter int FRAC_BITS = 20,
  parameter int IN_WIDTH  = 24,
  parameter int OUT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  mi3_mat_if.sink   mat,
  mi3_res_if.source res
);

  localparam int AW  = 2*IN_WIDTH + 1;
  localparam int DW  = 3*IN_WIDTH + 3;
  localparam int LAT = OUT_WIDTH + 3;
  localparam int PW  = mi3_pkg::N_ELEM*OUT_WIDTH + 1;

  logic                        en;
  logic                        full;
  logic signed [IN_WIDTH-1:0]  m [mi3_pkg::N_ELEM];
  logic                        fv;
  logic signed [AW-1:0]        adj [mi3_pkg::N_ELEM];
  logic signed [DW-1:0]        det;
  mi3_pkg::tag_t               tag [LAT];
  logic [OUT_WIDTH-1:0]        quo [mi3_pkg::N_ELEM];
  logic [mi3_pkg::N_ELEM-1:0]  fit;
  logic                        push;
  logic                        okc;
  logic [PW-1:0]               pdata;
  logic [PW-1:0]               odata;

  assign en        = ~full;
  assign mat.ready = en;

  assign m[0] = mat.m00;
  assign m[1] = mat.m01;
  assign m[2] = mat.m02;
  assign m[3] = mat.m10;
  assign m[4] = mat.m11;
  assign m[5] = mat.m12;
  assign m[6] = mat.m20;
  assign m[7] = mat.m21;
  assign m[8] = mat.m22;

  mi3_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (mat.valid),
    .m       (m),
    .out_vld (fv),
    .adj     (adj),
    .det     (det)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) tag[i].vld <= 1'b0;
    end else if (en) begin
      tag[0].vld  <= fv;
      tag[0].sing <= (det == '0);
      for (int i = 1; i < LAT; i++) tag[i] <= tag[i-1];
    end
  end

  for (genvar i = 0; i < mi3_pkg::N_ELEM; i++) begin : g_lane
    mi3_lane #(
      .IN_WIDTH  (IN_WIDTH),
      .OUT_WIDTH (OUT_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .adj (adj[i]),
      .det (det),
      .quo (quo[i]),
      .fit (fit[i])
    );
    assign pdata[i*OUT_WIDTH +: OUT_WIDTH] = okc ? quo[i] : '0;
  end

  assign okc       = (&fit) & ~tag[LAT-1].sing;
  assign pdata[PW-1] = okc;
  assign push      = tag[LAT-1].vld & en;

  mi3_outq #(.WIDTH(PW)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (pdata),
    .full      (full),
    .out_vld   (res.valid),
    .out_rdy   (res.ready),
    .out_data  (odata)
  );

  assign res.inv00 = odata[0*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv01 = odata[1*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv02 = odata[2*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv10 = odata[3*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv11 = odata[4*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv12 = odata[5*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv20 = odata[6*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv21 = odata[7*OUT_WIDTH +: OUT_WIDTH];
  assign res.inv22 = odata[8*OUT_WIDTH +: OUT_WIDTH];
  assign res.ok    = odata[PW-1];

  `MI3_CHK_IMPL(a_sing_not_ok, push && tag[LAT-1].sing, !pdata[PW-1], "singular beat flagged ok")
  `MI3_CHK_IMPL(a_stall_has_out, !mat.ready, res.valid, "input stalled with empty queue")
  `MI3_CHK_NEXT(a_hold_tail, !en, $stable(tag[LAT-1]), "pipeline tail moved during stall")

endmodule
